@@ hw/rtl/nmu_pkg.sv @@
`default_nettype none

package nmu_pkg;

  // default store dimensions
  localparam int ROWS_MAX_DEF = 64;
  localparam int COLS_MAX_DEF = 64;
  localparam int RANK_MAX_DEF = 8;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  // item kinds
  typedef enum logic [2:0] {
    KIND_WR_V = 3'd0,
    KIND_WR_W = 3'd1,
    KIND_WR_H = 3'd2,
    KIND_RUN  = 3'd3,
    KIND_RD_W = 3'd4,
    KIND_RD_H = 3'd5
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_RANK  = 2'd2,
    REG_ITERS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        saturated;
    logic        run_done;
  } out_item_t;

  // running sum with sticky overflow above 32 bits
  typedef struct packed {
    logic        over;
    logic [31:0] val;
  } acc_t;

  // divider result
  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] quot;
  } div_res_t;

  // control of the accumulator chain
  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ITEM_RD,
    ST_ITEM_OUT,
    ST_RUN_OUT,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_DIV_LD,
    ST_DIV,
    ST_DRAIN,
    ST_SUM_END
  } state_t;

  typedef enum logic [2:0] {
    PH_RATIO1,
    PH_WSUM,
    PH_PROD1,
    PH_HUPD,
    PH_HSUM,
    PH_RATIO2,
    PH_PROD2,
    PH_WUPD
  } phase_t;

  function automatic acc_t acc_add(acc_t a, logic [47:0] term);
    logic [48:0] s;
    acc_t        r;
    s      = {17'b0, a.val} + {1'b0, term};
    r.over = a.over | (|s[48:32]);
    r.val  = s[31:0];
    return r;
  endfunction

  function automatic logic [31:0] acc_sat(acc_t a);
    return a.over ? SAT32 : a.val;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/nmf_multiplicative_update.sv @@
`default_nettype none

// Nonnegative matrix factorisation V ~ W*H by KL multiplicative updates, Q16.16.
// Input channel: an item is taken when start is high and busy is low. Kinds write
// an entry of V, W or H (written on acceptance, busy stays low, no result), start a run, or read
// an entry of W or H. Results appear on out_data for one cycle with out_strobe;
// the receiver cannot stall, so each result is taken in the cycle it is shown.
// A read item reads the store in ST_ITEM_RD and shows its result in ST_ITEM_OUT, busy high meanwhile.
// A run gives one result with run_done set when all iterations finish.
// Each iteration, with r, c, k the used rows, cols and rank, runs its passes in order:
//   a ratio pass over the r*c entries of V, W column sums, W'R, H update, H row sums,
//   a second ratio pass, RH', W update. All products go through the single shared
// multiplier and all quotients through the restoring divider; a saturating division
// ends early. The rank-long chain of accumulator cells collects k sums at once.
// The user must send configuration over the APB-style port while the block is idle; the block does not check.
// Reset returns the control to idle and the registers to their reset values;
// store contents are undefined until written.
module nmf_multiplicative_update import nmu_pkg::*; #(
  parameter int ROWS_MAX = ROWS_MAX_DEF,
  parameter int COLS_MAX = COLS_MAX_DEF,
  parameter int RANK_MAX = RANK_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_strobe,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW    = $clog2(ROWS_MAX);
  localparam int CW    = $clog2(COLS_MAX);
  localparam int KW    = (RANK_MAX > 1) ? $clog2(RANK_MAX) : 1;
  localparam int LINES = (ROWS_MAX > COLS_MAX) ? ROWS_MAX : COLS_MAX;
  localparam int VD    = ROWS_MAX * COLS_MAX;
  localparam int WD    = ROWS_MAX * RANK_MAX;
  localparam int HD    = RANK_MAX * COLS_MAX;
  localparam int PD    = LINES * RANK_MAX;
  localparam int VAW   = $clog2(VD);
  localparam int WAW   = $clog2(WD);
  localparam int HAW   = $clog2(HD);
  localparam int PAW   = $clog2(PD);
  localparam int ROWS_RST = (ROWS_MAX < 64) ? ROWS_MAX : 64;
  localparam int COLS_RST = (COLS_MAX < 64) ? COLS_MAX : 64;
  localparam int RANK_RST = (RANK_MAX < 8) ? RANK_MAX : 8;

  // configuration registers
  logic [6:0]  rows_r;
  logic [6:0]  cols_r;
  logic [3:0]  rank_r;
  logic [15:0] iters_r;
  logic        cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= 7'(ROWS_RST);
      cols_r  <= 7'(COLS_RST);
      rank_r  <= 4'(RANK_RST);
      iters_r <= 16'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_ROWS:  rows_r  <= pwdata[6:0];
        REG_COLS:  cols_r  <= pwdata[6:0];
        REG_RANK:  rank_r  <= pwdata[3:0];
        REG_ITERS: iters_r <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_ROWS:  prdata = {25'b0, rows_r};
      REG_COLS:  prdata = {25'b0, cols_r};
      REG_RANK:  prdata = {28'b0, rank_r};
      REG_ITERS: prdata = {16'b0, iters_r};
      default:   prdata = '0;
    endcase
  end

  // clamped loop bounds
  logic [31:0] nr_c, nc_c, nk_c;

  always_comb begin
    nr_c = (rows_r == 7'd0) ? 32'd1 :
           ({25'b0, rows_r} > 32'(ROWS_MAX)) ? 32'(ROWS_MAX) : {25'b0, rows_r};
    nc_c = (cols_r == 7'd0) ? 32'd1 :
           ({25'b0, cols_r} > 32'(COLS_MAX)) ? 32'(COLS_MAX) : {25'b0, cols_r};
    nk_c = (rank_r == 4'd0) ? 32'd1 :
           ({28'b0, rank_r} > 32'(RANK_MAX)) ? 32'(RANK_MAX) : {28'b0, rank_r};
  end

  // sequencer registers
  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [RW-1:0] ci_r, ci_nxt, nr_m1_r, nr_m1_nxt;
  logic [CW-1:0] cj_r, cj_nxt, nc_m1_r, nc_m1_nxt;
  logic [KW-1:0] ck_r, ck_nxt, nk_m1_r, nk_m1_nxt;
  logic [15:0] iter_r, iter_nxt;
  acc_t        acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic        flag_r, flag_nxt;
  logic [31:0] wcs_r [RANK_MAX];
  logic [31:0] hrs_r [RANK_MAX];

  // latched read item
  logic [5:0]  it_row_r;
  logic [5:0]  it_col_r;
  logic        it_h_r;
  logic        it_ok_r;

  // item decode
  logic accept;
  logic row_r_ok, row_k_ok, col_c_ok, col_k_ok;
  logic ok_v, ok_w, ok_h;

  assign accept   = start & (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign row_r_ok = (32'(in_data.row) < 32'(ROWS_MAX));
  assign row_k_ok = (32'(in_data.row) < 32'(RANK_MAX));
  assign col_c_ok = (32'(in_data.col) < 32'(COLS_MAX));
  assign col_k_ok = (32'(in_data.col) < 32'(RANK_MAX));
  assign ok_v     = row_r_ok & col_c_ok;
  assign ok_w     = row_r_ok & col_k_ok;
  assign ok_h     = row_k_ok & col_c_ok;

  always_ff @(posedge clk) begin
    if (accept) begin
      it_row_r <= in_data.row;
      it_col_r <= in_data.col;
      it_h_r   <= (in_data.kind == KIND_RD_H);
      it_ok_r  <= (in_data.kind == KIND_RD_H) ? ok_h : ok_w;
    end
  end

  // phase groups
  logic ratio_ph, sum_ph, chain_ph, k_last, i_last, j_last;

  assign ratio_ph = (phase_r == PH_RATIO1) || (phase_r == PH_RATIO2);
  assign sum_ph   = (phase_r == PH_WSUM) || (phase_r == PH_HSUM);
  assign chain_ph = sum_ph || (phase_r == PH_PROD1) || (phase_r == PH_PROD2);
  assign k_last   = (ck_r == nk_m1_r);
  assign i_last   = (ci_r == nr_m1_r);
  assign j_last   = (cj_r == nc_m1_r);

  // store addresses
  logic [VAW-1:0] vr_addr, v_waddr;
  logic [WAW-1:0] w_raddr, w_waddr, w_run_addr;
  logic [HAW-1:0] h_raddr, h_waddr, h_run_addr;
  logic [PAW-1:0] p_addr;
  logic [31:0]    line;

  always_comb begin
    vr_addr    = VAW'(32'(ci_r) * 32'(COLS_MAX) + 32'(cj_r));
    v_waddr    = VAW'(32'(in_data.row) * 32'(COLS_MAX) + 32'(in_data.col));
    w_run_addr = WAW'(32'(ci_r) * 32'(RANK_MAX) + 32'(ck_r));
    h_run_addr = HAW'(32'(ck_r) * 32'(COLS_MAX) + 32'(cj_r));
    w_raddr    = (state_r == ST_ITEM_RD) ?
                 WAW'(32'(it_row_r) * 32'(RANK_MAX) + 32'(it_col_r)) : w_run_addr;
    h_raddr    = (state_r == ST_ITEM_RD) ?
                 HAW'(32'(it_row_r) * 32'(COLS_MAX) + 32'(it_col_r)) : h_run_addr;
    w_waddr    = (state_r == ST_IDLE) ?
                 WAW'(32'(in_data.row) * 32'(RANK_MAX) + 32'(in_data.col)) : w_run_addr;
    h_waddr    = (state_r == ST_IDLE) ?
                 HAW'(32'(in_data.row) * 32'(COLS_MAX) + 32'(in_data.col)) : h_run_addr;
    line       = ((phase_r == PH_PROD1) || (phase_r == PH_HUPD)) ? 32'(cj_r) : 32'(ci_r);
    p_addr     = PAW'(line * 32'(RANK_MAX) + 32'(ck_r));
  end

  // divider and chain hookup
  div_res_t    div_res;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic        div_start;
  acc_t        chain_q  [RANK_MAX];
  acc_t        chain_in [RANK_MAX];
  acc_t        tail_src;
  cell_ctl_t   cell_ctl;
  logic [47:0] term;
  logic [47:0] head_term;
  logic        run_start;

  // stores
  logic [31:0] v_mem [VD];
  logic [31:0] r_mem [VD];
  logic [31:0] w_mem [WD];
  logic [31:0] h_mem [HD];
  logic [31:0] p_mem [PD];
  logic [31:0] v_rd_r, r_rd_r, w_rd_r, h_rd_r, p_rd_r;
  logic        v_we, r_we, w_we, h_we, p_we;
  logic        div_wb;

  assign div_wb = (state_r == ST_DIV) && div_res.done;
  assign v_we   = accept && (in_data.kind == KIND_WR_V) && ok_v;
  assign w_we   = (accept && (in_data.kind == KIND_WR_W) && ok_w) ||
                  (div_wb && (phase_r == PH_WUPD));
  assign h_we   = (accept && (in_data.kind == KIND_WR_H) && ok_h) ||
                  (div_wb && (phase_r == PH_HUPD));
  assign r_we   = div_wb && ratio_ph;
  assign p_we   = (state_r == ST_DRAIN);

  always_ff @(posedge clk) begin
    if (v_we) begin
      v_mem[v_waddr] <= in_data.value;
    end
    v_rd_r <= v_mem[vr_addr];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      r_mem[vr_addr] <= div_res.quot;
    end
    r_rd_r <= r_mem[vr_addr];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_waddr] <= (state_r == ST_IDLE) ? in_data.value : div_res.quot;
    end
    w_rd_r <= w_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      h_mem[h_waddr] <= (state_r == ST_IDLE) ? in_data.value : div_res.quot;
    end
    h_rd_r <= h_mem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[p_addr] <= acc_sat(chain_q[0]);
    end
    p_rd_r <= p_mem[p_addr];
  end

  // operand selection
  logic [31:0] op_a, op_b;

  always_comb begin
    case (phase_r)
      PH_RATIO1, PH_RATIO2: begin op_a = w_rd_r; op_b = h_rd_r; end
      PH_PROD1:             begin op_a = w_rd_r; op_b = r_rd_r; end
      PH_HUPD:              begin op_a = h_rd_r; op_b = p_rd_r; end
      PH_PROD2:             begin op_a = r_rd_r; op_b = h_rd_r; end
      PH_WUPD:              begin op_a = w_rd_r; op_b = p_rd_r; end
      default:              begin op_a = '0;     op_b = '0;     end
    endcase
  end

  always_comb begin
    term      = sum_ph ? {16'b0, ((phase_r == PH_WSUM) ? w_rd_r : h_rd_r)} : prod_r[63:16];
    head_term = ((state_r == ST_ACC) && chain_ph) ? term : '0;
    div_start = (state_r == ST_DIV_LD);
    div_num   = ratio_ph ? {16'b0, v_rd_r, 16'b0} : prod_r;
    if (ratio_ph) begin
      div_den = acc_sat(acc_r);
    end else if (phase_r == PH_HUPD) begin
      div_den = wcs_r[ck_r];
    end else begin
      div_den = hrs_r[ck_r];
    end
  end

  nmu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  // ring of accumulator cells, rotated over the used rank
  assign run_start      = accept && (in_data.kind == KIND_RUN);
  assign tail_src       = (state_r == ST_DRAIN) ? acc_t'('0) : chain_q[0];
  assign cell_ctl.shift = ((state_r == ST_ACC) && chain_ph) || (state_r == ST_DRAIN);
  assign cell_ctl.clr   = (state_r == ST_SUM_END) || run_start;

  for (genvar c = 0; c < RANK_MAX; c++) begin : g_cell
    if (c < RANK_MAX - 1) begin : g_mid
      assign chain_in[c] = (KW'(c) == nk_m1_r) ? tail_src : chain_q[c + 1];
    end else begin : g_end
      assign chain_in[c] = (KW'(c) == nk_m1_r) ? tail_src : acc_t'('0);
    end

    nmu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .term     ((c == 0) ? head_term : 48'd0),
      .link_in  (chain_in[c]),
      .link_out (chain_q[c])
    );
  end

  // column and row sums of the factors
  logic any_over;

  always_comb begin
    any_over = 1'b0;
    for (int c = 0; c < RANK_MAX; c++) begin
      any_over = any_over | chain_q[c].over;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < RANK_MAX; c++) begin
        wcs_r[c] <= '0;
        hrs_r[c] <= '0;
      end
    end else if (state_r == ST_SUM_END) begin
      for (int c = 0; c < RANK_MAX; c++) begin
        if (phase_r == PH_WSUM) begin
          wcs_r[c] <= acc_sat(chain_q[c]);
        end else begin
          hrs_r[c] <= acc_sat(chain_q[c]);
        end
      end
    end
  end

  // sequencer
  always_comb begin
    logic phase_done;
    phase_done = 1'b0;
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    ci_nxt     = ci_r;
    cj_nxt     = cj_r;
    ck_nxt     = ck_r;
    nr_m1_nxt  = nr_m1_r;
    nc_m1_nxt  = nc_m1_r;
    nk_m1_nxt  = nk_m1_r;
    iter_nxt   = iter_r;
    acc_nxt    = acc_r;
    prod_nxt   = prod_r;
    flag_nxt   = flag_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_data.kind)
            KIND_RUN: begin
              nr_m1_nxt = RW'(nr_c - 32'd1);
              nc_m1_nxt = CW'(nc_c - 32'd1);
              nk_m1_nxt = KW'(nk_c - 32'd1);
              flag_nxt  = 1'b0;
              ci_nxt    = '0;
              cj_nxt    = '0;
              ck_nxt    = '0;
              acc_nxt   = '0;
              phase_nxt = PH_RATIO1;
              iter_nxt  = iters_r;
              state_nxt = (iters_r == 16'd0) ? ST_RUN_OUT : ST_RD;
            end
            KIND_RD_W, KIND_RD_H: state_nxt = ST_ITEM_RD;
            default: ;
          endcase
        end
      end
      ST_ITEM_RD:  state_nxt = ST_ITEM_OUT;
      ST_ITEM_OUT: state_nxt = ST_IDLE;
      ST_RUN_OUT:  state_nxt = ST_IDLE;
      ST_RD:       state_nxt = sum_ph ? ST_ACC : ST_MUL;
      ST_MUL: begin
        prod_nxt  = 64'(op_a) * 64'(op_b);
        state_nxt = ((phase_r == PH_HUPD) || (phase_r == PH_WUPD)) ? ST_DIV_LD : ST_ACC;
      end
      ST_ACC: begin
        if (ratio_ph) begin
          acc_nxt = acc_add(acc_r, prod_r[63:16]);
          if (k_last) begin
            state_nxt = ST_DIV_LD;
          end else begin
            ck_nxt    = ck_r + 1'b1;
            state_nxt = ST_RD;
          end
        end else if (!k_last) begin
          ck_nxt    = ck_r + 1'b1;
          state_nxt = ST_RD;
        end else begin
          ck_nxt    = '0;
          state_nxt = ST_RD;
          case (phase_r)
            PH_WSUM: begin
              if (i_last) begin ci_nxt = '0; state_nxt = ST_SUM_END; end
              else ci_nxt = ci_r + 1'b1;
            end
            PH_HSUM: begin
              if (j_last) begin cj_nxt = '0; state_nxt = ST_SUM_END; end
              else cj_nxt = cj_r + 1'b1;
            end
            PH_PROD1: begin
              if (i_last) begin ci_nxt = '0; state_nxt = ST_DRAIN; end
              else ci_nxt = ci_r + 1'b1;
            end
            PH_PROD2: begin
              if (j_last) begin cj_nxt = '0; state_nxt = ST_DRAIN; end
              else cj_nxt = cj_r + 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_DIV_LD: begin
        if (ratio_ph && acc_r.over) begin
          flag_nxt = 1'b1;
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (div_res.sat) begin
            flag_nxt = 1'b1;
          end
          state_nxt = ST_RD;
          if (ratio_ph) begin
            acc_nxt = '0;
            ck_nxt  = '0;
            if (j_last) begin
              cj_nxt = '0;
              if (i_last) begin ci_nxt = '0; phase_done = 1'b1; end
              else ci_nxt = ci_r + 1'b1;
            end else begin
              cj_nxt = cj_r + 1'b1;
            end
          end else if (phase_r == PH_HUPD) begin
            if (j_last) begin
              cj_nxt = '0;
              if (k_last) begin ck_nxt = '0; phase_done = 1'b1; end
              else ck_nxt = ck_r + 1'b1;
            end else begin
              cj_nxt = cj_r + 1'b1;
            end
          end else begin
            if (k_last) begin
              ck_nxt = '0;
              if (i_last) begin ci_nxt = '0; phase_done = 1'b1; end
              else ci_nxt = ci_r + 1'b1;
            end else begin
              ck_nxt = ck_r + 1'b1;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (chain_q[0].over) begin
          flag_nxt = 1'b1;
        end
        if (k_last) begin
          ck_nxt    = '0;
          state_nxt = ST_RD;
          if (phase_r == PH_PROD1) begin
            if (j_last) begin cj_nxt = '0; phase_done = 1'b1; end
            else cj_nxt = cj_r + 1'b1;
          end else begin
            if (i_last) begin ci_nxt = '0; phase_done = 1'b1; end
            else ci_nxt = ci_r + 1'b1;
          end
        end else begin
          ck_nxt = ck_r + 1'b1;
        end
      end
      ST_SUM_END: begin
        if (any_over) begin
          flag_nxt = 1'b1;
        end
        phase_done = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // move on to the next pass of the iteration
    if (phase_done) begin
      ci_nxt    = '0;
      cj_nxt    = '0;
      ck_nxt    = '0;
      acc_nxt   = '0;
      state_nxt = ST_RD;
      case (phase_r)
        PH_RATIO1: phase_nxt = PH_WSUM;
        PH_WSUM:   phase_nxt = PH_PROD1;
        PH_PROD1:  phase_nxt = PH_HUPD;
        PH_HUPD:   phase_nxt = PH_HSUM;
        PH_HSUM:   phase_nxt = PH_RATIO2;
        PH_RATIO2: phase_nxt = PH_PROD2;
        PH_PROD2:  phase_nxt = PH_WUPD;
        default: begin
          phase_nxt = PH_RATIO1;
          if (iter_r == 16'd1) begin
            state_nxt = ST_RUN_OUT;
          end else begin
            iter_nxt = iter_r - 16'd1;
          end
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_RATIO1;
      ci_r    <= '0;
      cj_r    <= '0;
      ck_r    <= '0;
      nr_m1_r <= '0;
      nc_m1_r <= '0;
      nk_m1_r <= '0;
      iter_r  <= '0;
      acc_r   <= '0;
      flag_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ci_r    <= ci_nxt;
      cj_r    <= cj_nxt;
      ck_r    <= ck_nxt;
      nr_m1_r <= nr_m1_nxt;
      nc_m1_r <= nc_m1_nxt;
      nk_m1_r <= nk_m1_nxt;
      iter_r  <= iter_nxt;
      acc_r   <= acc_nxt;
      flag_r  <= flag_nxt;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // result item
  always_comb begin
    out_strobe          = (state_r == ST_ITEM_OUT) || (state_r == ST_RUN_OUT);
    out_data.read_value = ((state_r == ST_ITEM_OUT) && it_ok_r) ?
                          (it_h_r ? h_rd_r : w_rd_r) : 32'd0;
    out_data.saturated  = flag_r;
    out_data.run_done   = (state_r == ST_RUN_OUT);
  end

endmodule

`default_nettype wire

@@ hw/rtl/nmu_cell.sv @@
`default_nettype none

module nmu_cell import nmu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cell_ctl_t   ctl,
  input  logic [47:0] term,
  input  acc_t        link_in,
  output acc_t        link_out
);

  acc_t val_r;

  // held partial sum, takes the neighbour's value on each shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (ctl.clr) begin
      val_r <= '0;
    end else if (ctl.shift) begin
      val_r <= link_in;
    end
  end

  // own value plus the incoming term, handed on along the ring
  assign link_out = acc_add(val_r, term);

endmodule

`default_nettype wire

@@ hw/rtl/nmu_div.sv @@
`default_nettype none

module nmu_div import nmu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output div_res_t    res
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic        sat_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] den_r;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        qbit;
  logic [31:0] rem_nxt;
  logic        early;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial   = {rem_r, quo_r[31]};
    diff    = trial - {1'b0, den_r};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? diff[31:0] : trial[31:0];
    early   = (den == 32'd0) || (num[63:32] >= den);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= '0;
        busy_r <= !early;
        done_r <= early;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, zero divisor or quotient above 32 bits saturates
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      sat_r <= early;
      rem_r <= num[63:32];
      quo_r <= early ? SAT32 : num[31:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[30:0], qbit};
    end
  end

  assign res.done = done_r;
  assign res.sat  = sat_r;
  assign res.quot = quo_r;

endmodule

`default_nettype wire
